@@ hdl/red_pkg.sv @@
// ----------------------------------------------------------------------------
// red_pkg: rotary encoder event decoder shared definitions
// Word types, event codes, register map and reset values.
// ----------------------------------------------------------------------------
package red_pkg;

  typedef struct packed {
    logic [15:0] counter_value;
    logic        button_released;
    logic [31:0] now_ms;
  } red_in_t;

  typedef struct packed {
    logic        [1:0]  event_kind;
    logic signed [15:0] steps;
  } red_out_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  // event codes
  localparam logic [1:0] EV_ROTATE = 2'd0;
  localparam logic [1:0] EV_CLICK  = 2'd1;
  localparam logic [1:0] EV_LONG   = 2'd2;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_CPD   = 2'd0;
  localparam logic [1:0] REG_DEB   = 2'd1;
  localparam logic [1:0] REG_LONG  = 2'd2;

  localparam int unsigned AddrW = 4;

  localparam logic [2:0]  CpdRst  = 3'd2;
  localparam logic [15:0] DebRst  = 16'd20;
  localparam logic [15:0] LongRst = 16'd1000;

  localparam logic [15:0] StepsPosMax = 16'd32767;
  localparam logic [15:0] StepsNegMax = 16'd32768;

  // divisor actually used: 0 acts as 1, 5..7 act as 4
  function automatic logic [2:0] clamp_div(input logic [2:0] cpd);
    logic [2:0] d;
    if (cpd == 3'd0) begin
      d = 3'd1;
    end else if (cpd > 3'd4) begin
      d = 3'd4;
    end else begin
      d = cpd;
    end
    return d;
  endfunction

endpackage

@@ hdl/red_alu.sv @@
// ----------------------------------------------------------------------------
// red_alu: shared 32-bit add/subtract unit
// Result plus unsigned a >= b flag (valid for subtract).
// ----------------------------------------------------------------------------
module red_alu import red_pkg::*; (
  input  alu_op_e     op_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] res_o,
  output logic        ge_o
);

  logic [32:0] sum;

  always_comb begin
    case (op_i)
      ALU_SUB: sum = {1'b0, a_i} + {1'b0, ~b_i} + 33'd1;
      ALU_ADD: sum = {1'b0, a_i} + {1'b0, b_i};
      default: sum = {1'b0, a_i} + {1'b0, b_i};
    endcase
  end

  assign res_o = sum[31:0];
  assign ge_o  = sum[32];  // carry out of a - b: no borrow

endmodule

@@ hdl/red_dstep.sv @@
// ----------------------------------------------------------------------------
// red_dstep: radix-4 restoring division step
// Two quotient bits per call, divisor 1..4, remainder below 4.
// ----------------------------------------------------------------------------
module red_dstep (
  input  logic [1:0] rem_i,
  input  logic [1:0] bits_i,
  input  logic [2:0] div_i,
  output logic [1:0] rem_o,
  output logic [1:0] q_o
);

  logic [2:0] r1, r1s, r2, r2s;

  always_comb begin
    r1     = {rem_i, bits_i[1]};
    q_o[1] = (r1 >= div_i);
    r1s    = q_o[1] ? (r1 - div_i) : r1;
    r2     = {r1s[1:0], bits_i[0]};
    q_o[0] = (r2 >= div_i);
    r2s    = q_o[0] ? (r2 - div_i) : r2;
    rem_o  = r2s[1:0];
  end

endmodule

@@ hdl/rotary_encoder_event_decoder_top.sv @@
// ----------------------------------------------------------------------------
// rotary_encoder_event_decoder_top: encoder detent and button event decoder
// Turns encoder counter polls into rotate, click and long press events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o, in_word_i): one poll word with the
//   16-bit counter, raw button level and millisecond timestamp.
//   Output channel (out_valid_o/out_ready_i, out_word_o): zero or one event
//   word per poll (rotate with signed detents, click, long press).
//   APB port: detent size at 0x0, debounce time at 0x4, long press time
//   at 0x8; write only while idle.
// Timing: one poll at a time. in_ready_o is high only in IDLE. The first
//   poll after reset takes the baseline in the accept cycle and leaves the
//   block ready. Any other poll runs delta, sum, magnitude, 8 radix-4
//   divide steps, sign fix and output load for a rotate event; with no
//   rotation the sign fix goes on to the button path (raw level, debounce
//   delta and compare, long press delta and compare on a release). The
//   next poll is taken once the block is back in IDLE. The poll rate is set
//   by the single shared 32-bit subtractor, reused for every delta, compare
//   and negate, and by the 2-bit-per-cycle divider.
// Reset: control state returns to its reset values (payload registers
//   are not reset); the next poll is a baseline poll. Stall: the event
//   waits in a one-word output register; while it is held, a finished new
//   event waits in EMIT and no new poll is taken until it is loaded.
// ----------------------------------------------------------------------------
module rotary_encoder_event_decoder_top import red_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // poll words
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  red_in_t          in_word_i,
  // event words
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output red_out_t         out_word_o,
  // APB configuration
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // sequencer codes
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DELTA = 4'd1;
  localparam logic [3:0] S_SUM   = 4'd2;
  localparam logic [3:0] S_ABS   = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_SIGN  = 4'd5;
  localparam logic [3:0] S_BTN   = 4'd6;
  localparam logic [3:0] S_DEBD  = 4'd7;
  localparam logic [3:0] S_DEBC  = 4'd8;
  localparam logic [3:0] S_LPD   = 4'd9;
  localparam logic [3:0] S_LPC   = 4'd10;
  localparam logic [3:0] S_EMIT  = 4'd11;

  // --- configuration registers ---
  logic [2:0]  cpd_q;
  logic [15:0] deb_q, long_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpd_q  <= CpdRst;
      deb_q  <= DebRst;
      long_q <= LongRst;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_CPD:  cpd_q  <= pwdata[2:0];
        REG_DEB:  deb_q  <= pwdata[15:0];
        REG_LONG: long_q <= pwdata[15:0];
        default:  ;  // unmapped: ignored
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CPD:  prdata = {29'd0, cpd_q};
      REG_DEB:  prdata = {16'd0, deb_q};
      REG_LONG: prdata = {16'd0, long_q};
      default:  prdata = 32'd0;
    endcase
  end

  // --- sequencer and decoder state ---
  logic [3:0]  state_q, state_d;
  logic [15:0] prev_q, prev_d;     // last counter value
  logic [2:0]  rem_q, rem_d;       // signed detent remainder
  logic        raw_q, raw_d;       // last raw level
  logic [31:0] lct_q, lct_d;       // time of last raw change
  logic        stable_q, stable_d; // debounced level
  logic [31:0] pst_q, pst_d;       // press start time
  logic        base_q, base_d;     // baseline taken
  logic        neg_q, neg_d;       // sum sign
  logic [1:0]  drem_q, drem_d;     // divider partial remainder
  logic [2:0]  iter_q, iter_d;
  logic        ovld_q, ovld_d;

  // payload (no reset)
  red_in_t     poll_q, poll_d;
  logic [31:0] acc_q, acc_d;
  red_out_t    res_q, res_d;
  red_out_t    out_q, out_d;

  // shared unit
  alu_op_e     alu_op;
  logic [31:0] alu_a, alu_b, alu_res;
  logic        alu_ge;

  red_alu u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res),
    .ge_o  (alu_ge)
  );

  // divider step
  logic [2:0] div_val;
  logic [1:0] ds_rem, ds_q;

  assign div_val = clamp_div(cpd_q);

  red_dstep u_dstep (
    .rem_i  (drem_q),
    .bits_i (acc_q[15:14]),
    .div_i  (div_val),
    .rem_o  (ds_rem),
    .q_o    (ds_q)
  );

  // saturated quotient magnitude
  logic [15:0] qsat;
  always_comb begin
    if (neg_q) begin
      qsat = (acc_q[15:0] > StepsNegMax) ? StepsNegMax : acc_q[15:0];
    end else begin
      qsat = (acc_q[15:0] > StepsPosMax) ? StepsPosMax : acc_q[15:0];
    end
  end

  // shared unit operand select
  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = 32'd0;
    alu_b  = 32'd0;
    case (state_q)
      S_DELTA: begin
        alu_op = ALU_SUB;
        alu_a  = {16'd0, poll_q.counter_value};
        alu_b  = {16'd0, prev_q};
      end
      S_SUM: begin
        alu_a = {{16{acc_q[15]}}, acc_q[15:0]};
        alu_b = {{29{rem_q[2]}}, rem_q};
      end
      S_ABS: begin
        alu_op = ALU_SUB;
        alu_b  = acc_q;
      end
      S_SIGN: begin
        alu_op = neg_q ? ALU_SUB : ALU_ADD;
        alu_b  = {16'd0, qsat};
      end
      S_DEBD: begin
        alu_op = ALU_SUB;
        alu_a  = poll_q.now_ms;
        alu_b  = lct_q;
      end
      S_DEBC: begin
        alu_op = ALU_SUB;
        alu_a  = acc_q;
        alu_b  = {16'd0, deb_q};
      end
      S_LPD: begin
        alu_op = ALU_SUB;
        alu_a  = poll_q.now_ms;
        alu_b  = pst_q;
      end
      S_LPC: begin
        alu_op = ALU_SUB;
        alu_a  = acc_q;
        alu_b  = {16'd0, long_q};
      end
      default: ;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d  = state_q;
    prev_d   = prev_q;
    rem_d    = rem_q;
    raw_d    = raw_q;
    lct_d    = lct_q;
    stable_d = stable_q;
    pst_d    = pst_q;
    base_d   = base_q;
    neg_d    = neg_q;
    drem_d   = drem_q;
    iter_d   = iter_q;
    poll_d   = poll_q;
    acc_d    = acc_q;
    res_d    = res_q;
    out_d    = out_q;
    ovld_d   = ovld_q & ~out_ready_i;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (!base_q) begin
            // baseline poll: capture only
            base_d   = 1'b1;
            prev_d   = in_word_i.counter_value;
            raw_d    = in_word_i.button_released;
            stable_d = in_word_i.button_released;
            lct_d    = in_word_i.now_ms;
          end else begin
            poll_d  = in_word_i;
            state_d = S_DELTA;
          end
        end
      end
      S_DELTA: begin
        acc_d   = alu_res;
        prev_d  = poll_q.counter_value;
        state_d = S_SUM;
      end
      S_SUM: begin
        acc_d   = alu_res;
        neg_d   = alu_res[31];
        state_d = S_ABS;
      end
      S_ABS: begin
        acc_d   = {16'd0, neg_q ? alu_res[15:0] : acc_q[15:0]};
        drem_d  = 2'd0;
        iter_d  = 3'd0;
        state_d = S_DIV;
      end
      S_DIV: begin
        acc_d  = {16'd0, acc_q[13:0], ds_q};
        drem_d = ds_rem;
        iter_d = iter_q + 3'd1;
        if (iter_q == 3'd7) begin
          state_d = S_SIGN;
        end
      end
      S_SIGN: begin
        rem_d = neg_q ? (3'd0 - {1'b0, drem_q}) : {1'b0, drem_q};
        if (acc_q[15:0] != 16'd0) begin
          res_d.event_kind = EV_ROTATE;
          res_d.steps      = alu_res[15:0];
          state_d          = S_EMIT;
        end else begin
          state_d = S_BTN;
        end
      end
      S_BTN: begin
        if (poll_q.button_released != raw_q) begin
          raw_d = poll_q.button_released;
          lct_d = poll_q.now_ms;
        end
        state_d = S_DEBD;
      end
      S_DEBD: begin
        acc_d   = alu_res;
        state_d = S_DEBC;
      end
      S_DEBC: begin
        state_d = S_IDLE;
        if (alu_ge && (poll_q.button_released != stable_q)) begin
          stable_d = poll_q.button_released;
          if (!poll_q.button_released) begin
            pst_d = poll_q.now_ms;  // press accepted, no event
          end else begin
            state_d = S_LPD;
          end
        end
      end
      S_LPD: begin
        acc_d   = alu_res;
        state_d = S_LPC;
      end
      S_LPC: begin
        res_d.event_kind = alu_ge ? EV_LONG : EV_CLICK;
        res_d.steps      = 16'sd0;
        state_d          = S_EMIT;
      end
      S_EMIT: begin
        if (!ovld_q || out_ready_i) begin
          out_d   = res_q;
          ovld_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      prev_q   <= 16'd0;
      rem_q    <= 3'd0;
      raw_q    <= 1'b1;
      lct_q    <= 32'd0;
      stable_q <= 1'b1;
      pst_q    <= 32'd0;
      base_q   <= 1'b0;
      neg_q    <= 1'b0;
      drem_q   <= 2'd0;
      iter_q   <= 3'd0;
      ovld_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      prev_q   <= prev_d;
      rem_q    <= rem_d;
      raw_q    <= raw_d;
      lct_q    <= lct_d;
      stable_q <= stable_d;
      pst_q    <= pst_d;
      base_q   <= base_d;
      neg_q    <= neg_d;
      drem_q   <= drem_d;
      iter_q   <= iter_d;
      ovld_q   <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    poll_q <= poll_d;
    acc_q  <= acc_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign out_valid_o = ovld_q;
  assign out_word_o  = out_q;

  // --- checks ---
  // remainder always within -3..3
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q != 3'b100)
    else $error("detent remainder out of range");

  // a non-baseline poll starts the sequencer
  a_poll_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && base_q) |=> (state_q == S_DELTA))
    else $error("accepted poll did not start");

  // rotate words never carry zero steps
  a_rot_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.event_kind == EV_ROTATE) |-> (out_word_o.steps != 16'sd0))
    else $error("rotate word with zero steps");

  // emit with a free output slot loads the word
  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && (!out_valid_o || out_ready_i)) |=> (out_valid_o && in_ready_o))
    else $error("event word not loaded");

endmodule

@@ sim/tb_rotary_encoder_event_decoder_top.sv @@
// ----------------------------------------------------------------------------
// tb_rotary_encoder_event_decoder_top: self-checking bench for the decoder
// Feeds poll words (counter, button level, timestamp) through the valid/ready
// input channel, configures the block over APB while it is idle, predicts
// every rotate, click and long press event and checks the event words in
// order. Both channels get random idle cycles.
// ----------------------------------------------------------------------------
module tb_rotary_encoder_event_decoder_top;
  import red_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // cycles an item with no event may still keep the block busy, plus margin
  localparam int unsigned DrainCycles = 40;
  // cycles without any accepted word before the run is declared hung
  localparam int unsigned StallLimit  = 2000;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  red_in_t          in_word_i;
  logic             out_valid_o;
  logic             out_ready_i;
  red_out_t         out_word_o;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rotary_encoder_event_decoder_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // --------------------------------------------------------------------------
  // Predictor state: a mirror of the registers and of the decoder state
  // --------------------------------------------------------------------------
  logic [2:0]  cpd_reg;
  logic [15:0] debounce_reg;
  logic [15:0] long_press_reg;

  bit          baseline_done;
  logic [15:0] last_count;
  int          remainder;      // signed, stays within -3..3
  logic        raw_level;
  logic        stable_level;
  logic [31:0] change_ms;
  logic [31:0] press_ms;

  red_out_t    pending_events[$];  // events predicted but not yet seen

  // stimulus-side encoder position and millisecond clock
  logic [15:0] enc_count;
  logic [31:0] clock_ms;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatch_count;
  int unsigned stall_cycles;

  // Works out the event (if any) one accepted poll word causes and updates
  // the mirrored state.
  function automatic void decode_poll(input red_in_t w);
    int                 divisor;
    int                 sum;
    int                 quo;
    logic signed [15:0] delta;
    logic [31:0]        held;
    red_out_t           ev;
    // first poll after reset only captures the baseline
    if (!baseline_done) begin
      baseline_done = 1'b1;
      last_count    = w.counter_value;
      raw_level     = w.button_released;
      stable_level  = w.button_released;
      change_ms     = w.now_ms;
      return;
    end
    // out-of-range detent settings fold into 1..4
    if (cpd_reg == 3'd0) begin
      divisor = 1;
    end else if (cpd_reg > 3'd4) begin
      divisor = 4;
    end else begin
      divisor = int'(cpd_reg);
    end
    delta      = w.counter_value - last_count;  // wraps mod 2^16
    sum        = remainder + int'(delta);
    last_count = w.counter_value;
    quo        = sum / divisor;                 // truncates toward zero
    remainder  = sum - quo * divisor;
    if (quo != 0) begin
      // only reachable past the steps range after a divisor change
      if (quo > 32767) begin
        quo = 32767;
      end else if (quo < -32768) begin
        quo = -32768;
      end
      ev.event_kind = EV_ROTATE;
      ev.steps      = quo[15:0];
      pending_events.push_back(ev);
      return;
    end
    // no rotation: debounce the button
    if (w.button_released != raw_level) begin
      raw_level = w.button_released;
      change_ms = w.now_ms;
    end
    held = w.now_ms - change_ms;
    if (held >= {16'd0, debounce_reg} && w.button_released != stable_level) begin
      stable_level = w.button_released;
      if (!w.button_released) begin
        press_ms = w.now_ms;
        return;
      end
      held          = w.now_ms - press_ms;
      ev.event_kind = (held >= {16'd0, long_press_reg}) ? EV_LONG : EV_CLICK;
      ev.steps      = '0;
      pending_events.push_back(ev);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Event checker: each accepted event word against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_events.size() == 0) begin
        $error("unexpected event word: event_kind %0d steps %0d",
               out_word_o.event_kind, $signed(out_word_o.steps));
        mismatch_count++;
      end else begin
        if (out_word_o.event_kind !== pending_events[0].event_kind) begin
          $error("event_kind: expected %0d, actual %0d",
                 pending_events[0].event_kind, out_word_o.event_kind);
          mismatch_count++;
        end
        if (out_word_o.steps !== pending_events[0].steps) begin
          $error("steps: expected %0d, actual %0d",
                 $signed(pending_events[0].steps), $signed(out_word_o.steps));
          mismatch_count++;
        end
        void'(pending_events.pop_front());
      end
    end
  end

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // hang detection: any accepted word on either channel restarts the count
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("[rotary_encoder_event_decoder_top] ERROR");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Sends one poll word; valid stays high from the previous word unless the
  // sender decides to idle this cycle.
  task automatic send_poll(input logic [15:0] count, input logic level,
                           input logic [31:0] ms);
    red_in_t w;
    w.counter_value   = count;
    w.button_released = level;
    w.now_ms          = ms;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    decode_poll(w);
  endtask

  // Drops valid, waits for every predicted event, then lets a poll that
  // causes no event run out before anything touches the registers.
  task automatic quiesce();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_CPD:  cpd_reg        = value[2:0];
      REG_DEB:  debounce_reg   = value[15:0];
      REG_LONG: long_press_reg = value[15:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_config(input logic [2:0] cpd, input logic [15:0] deb,
                              input logic [15:0] lng);
    quiesce();
    apb_write(REG_CPD, {29'd0, cpd});
    apb_write(REG_DEB, {16'd0, deb});
    apb_write(REG_LONG, {16'd0, lng});
  endtask

  // button poll with the encoder now and then nudged, so a rotation may
  // take the poll and skip the button
  task automatic button_poll(input logic level);
    if ($urandom_range(0, 9) == 0) begin
      enc_count += 16'($urandom_range(0, 8)) - 16'd4;
    end
    send_poll(enc_count, level, clock_ms);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset register values: 2 counts per detent, 20 ms debounce, 1000 ms long.
  task automatic test_directed_basics();
    send_poll(16'hFFFF, 1'b1, 32'hFFFF_FFF0);  // baseline only
    send_poll(16'h0001, 1'b1, 32'hFFFF_FFF1);  // +2 counts across wrap: +1
    send_poll(16'h0000, 1'b1, 32'hFFFF_FFF2);  // -1: truncates to 0, rem -1
    send_poll(16'hFFFF, 1'b1, 32'hFFFF_FFF3);  // -2 total: -1
    send_poll(16'h7FFE, 1'b1, 32'hFFFF_FFF4);  // largest positive delta
    send_poll(16'hFFFE, 1'b1, 32'hFFFF_FFF5);  // largest negative delta
    // press across the timestamp wrap, accepted exactly at the debounce time
    send_poll(16'hFFFE, 1'b0, 32'hFFFF_FFF8);
    send_poll(16'hFFFE, 1'b0, 32'h0000_000A);  // 18 ms: still bouncing
    send_poll(16'hFFFE, 1'b0, 32'h0000_000C);  // 20 ms: press taken at 12
    send_poll(16'hFFFE, 1'b1, 32'd992);
    send_poll(16'hFFFE, 1'b1, 32'd1012);       // held exactly 1000: long
    // held one ms short of the threshold: click
    send_poll(16'hFFFE, 1'b0, 32'd2000);
    send_poll(16'hFFFE, 1'b0, 32'd2020);
    send_poll(16'hFFFE, 1'b1, 32'd2999);
    send_poll(16'hFFFE, 1'b1, 32'd3019);
    // short glitch never becomes stable
    send_poll(16'hFFFE, 1'b0, 32'd4000);
    send_poll(16'hFFFE, 1'b1, 32'd4010);
    send_poll(16'hFFFE, 1'b1, 32'd4100);
    // rotation wins the poll, the press is taken on the next one
    send_poll(16'hFFFE, 1'b0, 32'd5000);
    send_poll(16'h0001, 1'b0, 32'd5030);
    send_poll(16'h0001, 1'b0, 32'd5031);
    send_poll(16'h0001, 1'b1, 32'd5100);
    send_poll(16'h0001, 1'b1, 32'd5120);
    enc_count = 16'h0001;
    clock_ms  = 32'd5120;
  endtask

  // A remainder left by a divisor of 4 meets a divisor of 1 and a full-range
  // delta: the steps value saturates in both directions.
  task automatic test_divisor_switch();
    apply_config(3'd1, 16'd20, 16'd1000);
    send_poll(enc_count, 1'b1, clock_ms + 1);  // flushes the remainder
    apply_config(3'd4, 16'd20, 16'd1000);
    enc_count += 16'd3;
    send_poll(enc_count, 1'b1, clock_ms + 2);  // remainder +3
    apply_config(3'd1, 16'd20, 16'd1000);
    enc_count += 16'h7FFF;
    send_poll(enc_count, 1'b1, clock_ms + 3);  // 32770 clips to 32767
    apply_config(3'd4, 16'd20, 16'd1000);
    enc_count -= 16'd3;
    send_poll(enc_count, 1'b1, clock_ms + 4);  // remainder -3
    apply_config(3'd1, 16'd20, 16'd1000);
    enc_count += 16'h8000;
    send_poll(enc_count, 1'b1, clock_ms + 5);  // -32771 clips to -32768
    clock_ms += 5;
  endtask

  // Mostly small turns, some full-range jumps and extreme deltas; the button
  // flips now and then.
  task automatic test_rotation(input logic [2:0] cpd, input int unsigned n_polls);
    logic level;
    level = 1'b1;
    apply_config(cpd, debounce_reg, long_press_reg);
    repeat (n_polls) begin
      case ($urandom_range(0, 9))
        0, 1:    enc_count += 16'($urandom());
        2:       enc_count += 16'h7FFF;
        3:       enc_count += 16'h8000;
        default: enc_count += 16'($urandom_range(0, 18)) - 16'd9;
      endcase
      if ($urandom_range(0, 9) == 0) level = ~level;
      clock_ms += $urandom_range(0, 40);
      send_poll(enc_count, level, clock_ms);
    end
  endtask

  // Full press/release cycles with bounce, timed around the debounce and
  // long press thresholds.
  task automatic test_button_timing(input logic [15:0] deb, input logic [15:0] lng,
                                    input int unsigned n_presses);
    logic [31:0] accept_ms;
    int unsigned hold;
    int unsigned extra;
    apply_config(cpd_reg, deb, lng);
    if ($urandom_range(0, 1)) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 200000);
    // settle in the released state
    clock_ms += 32'(deb) + 1;
    button_poll(1'b1);
    clock_ms += 32'(deb) + 1;
    button_poll(1'b1);
    repeat (n_presses) begin
      // contact bounce before the real press
      repeat ($urandom_range(0, 2)) begin
        clock_ms += $urandom_range(0, 32'(deb) / 2 + 1);
        button_poll(1'(~$urandom_range(0, 1)));
      end
      clock_ms += $urandom_range(1, 50);
      button_poll(1'b0);
      if (deb != 0 && $urandom_range(0, 1)) begin
        clock_ms += 32'(deb) - 1;              // one ms short
        button_poll(1'b0);
        clock_ms += 1;
      end else begin
        clock_ms += 32'(deb) + $urandom_range(0, 3);
      end
      button_poll(1'b0);
      accept_ms = clock_ms;
      case ($urandom_range(0, 3))
        0:       hold = 32'(lng) - 1;
        1:       hold = 32'(lng);
        2:       hold = 32'(lng) + 1;
        default: hold = $urandom_range(0, 2 * 32'(lng) + 32'(deb) + 10);
      endcase
      extra = $urandom_range(0, 2);
      if (hold < 32'(deb) + extra) hold = 32'(deb) + extra;
      repeat ($urandom_range(0, 2)) begin
        clock_ms = accept_ms + $urandom_range(0, hold / 2);
        button_poll(1'b0);
      end
      clock_ms = accept_ms + hold - 32'(deb) - extra;
      button_poll(1'b1);
      if (deb != 0 && extra == 0 && $urandom_range(0, 1)) begin
        clock_ms += 32'(deb) - 1;
        button_poll(1'b1);
      end
      clock_ms = accept_ms + hold;
      button_poll(1'b1);
    end
  endtask

  // Unrelated random fields: every bit of every field toggles.
  task automatic test_random_polls(input logic [2:0] cpd, input int unsigned n_polls);
    apply_config(cpd, 16'($urandom()), 16'($urandom()));
    repeat (n_polls) begin
      send_poll(16'($urandom()), 1'($urandom()), $urandom());
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_word_i      = '0;
    out_ready_i    = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    mismatch_count = 0;
    stall_cycles   = 0;
    // predictor starts from the reset values
    cpd_reg        = 3'd2;
    debounce_reg   = 16'd20;
    long_press_reg = 16'd1000;
    baseline_done  = 1'b0;
    last_count     = '0;
    remainder      = 0;
    raw_level      = 1'b1;
    stable_level   = 1'b1;
    change_ms      = '0;
    press_ms       = '0;
    enc_count      = '0;
    clock_ms       = '0;

    // round 1: sender rarely idles, receiver mostly stalls
    send_idle_pct = 6;
    recv_idle_pct = 67;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_basics();
    test_divisor_switch();
    test_rotation(3'd1, 80);
    test_rotation(3'd3, 80);
    test_button_timing(16'd0, 16'd0, 14);
    test_button_timing(16'd5, 16'd300, 14);
    test_random_polls(3'd6, 60);

    // round 2: the other way round
    send_idle_pct = 67;
    recv_idle_pct = 6;
    test_rotation(3'd0, 80);
    test_rotation(3'd4, 80);
    test_button_timing(16'hFFFF, 16'hFFFF, 14);
    test_button_timing(16'd37, 16'd120, 14);
    test_random_polls(3'($urandom()), 60);

    // round 3: full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_rotation(3'd7, 80);
    test_rotation(3'd5, 80);
    test_button_timing(16'd1, 16'hFFFF, 14);
    test_button_timing(16'd300, 16'd50, 14);
    test_random_polls(3'd2, 60);

    quiesce();
    if (mismatch_count == 0) begin
      $display("[rotary_encoder_event_decoder_top] OK");
    end else begin
      $display("[rotary_encoder_event_decoder_top] ERROR");
    end
    $finish;
  end

endmodule
